### design/lae_pkg.sv
package lae_pkg;

  // default table depth
  localparam int MaxStepsDefault = 32;

  // field widths
  localparam int CMD_W   = 3;
  localparam int IDX_W   = 5;
  localparam int MS_W    = 16;
  localparam int DUTY_W  = 8;
  localparam int LEN_W   = 6;
  localparam int MODE_W  = 2;
  localparam int CFG_W   = 16;
  localparam int CFGI_W  = 3;

  // shared divider widths
  localparam int DIV_W   = 25;
  localparam int DVS_W   = 16;
  localparam int DCNT_W  = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ON      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_OFF     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TOGGLE  = 3'd5;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_STATIC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BLINK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PULSE   = 2'd3;

  // register indexes
  localparam logic [CFGI_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFGI_W-1:0] REG_BRIGHTNESS = 3'd1;
  localparam logic [CFGI_W-1:0] REG_ACTIVE_HI  = 3'd2;
  localparam logic [CFGI_W-1:0] REG_BLINK      = 3'd3;
  localparam logic [CFGI_W-1:0] REG_PERIOD     = 3'd4;
  localparam logic [CFGI_W-1:0] REG_LENGTH     = 3'd5;

  // limits and reset values
  localparam logic [MS_W-1:0]   MS_MAX         = 16'd60000;
  localparam logic [MS_W-1:0]   MS_MIN         = 16'd1;
  localparam logic [MS_W-1:0]   PERIOD_MIN     = 16'd200;
  localparam logic [MS_W-1:0]   BLINK_RESET    = 16'd500;
  localparam logic [MS_W-1:0]   PERIOD_RESET   = 16'd2000;
  localparam logic [DUTY_W-1:0] BRIGHT_RESET   = 8'd255;
  localparam logic [LEN_W-1:0]  LEN_MIN        = 6'd2;
  localparam logic [MS_W-1:0]   ELAPSED_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DUTY_W-1:0] brightness;
    logic              active_high;
    logic [MS_W-1:0]   blink_interval;
    logic [MS_W-1:0]   pulse_period;
    logic [LEN_W-1:0]  pattern_length;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              lit;
    logic [IDX_W-1:0]  step_now;
    logic              animating;
  } res_t;

endpackage

### design/lae_regs.sv
module lae_regs
  import lae_pkg::*;
#(
  parameter int MAX_STEPS = MaxStepsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output cfg_t              cfg,
  output logic              mode_wr
);

  logic [LEN_W-1:0] len_raw;
  logic [LEN_W-1:0] len_clamped;

  // pattern length clamp to 2..MAX_STEPS
  assign len_raw = cfg_data[LEN_W-1:0];
  always_comb begin
    priority if (len_raw < LEN_MIN) begin
      len_clamped = LEN_MIN;
    end else if (32'(len_raw) > MAX_STEPS) begin
      len_clamped = LEN_W'(MAX_STEPS);
    end else begin
      len_clamped = len_raw;
    end
  end

  assign mode_wr = cfg_we && (cfg_index == REG_MODE);

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= MODE_STATIC;
      cfg.brightness     <= BRIGHT_RESET;
      cfg.active_high    <= 1'b1;
      cfg.blink_interval <= BLINK_RESET;
      cfg.pulse_period   <= PERIOD_RESET;
      cfg.pattern_length <= LEN_MIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:       cfg.mode <= cfg_data[MODE_W-1:0];
        REG_BRIGHTNESS: cfg.brightness <= cfg_data[DUTY_W-1:0];
        REG_ACTIVE_HI:  cfg.active_high <= cfg_data[0];
        REG_BLINK:      cfg.blink_interval <= cfg_data[MS_W-1:0];
        REG_PERIOD: begin
          cfg.pulse_period <= (cfg_data[MS_W-1:0] < PERIOD_MIN) ? PERIOD_MIN
                                                                : cfg_data[MS_W-1:0];
        end
        REG_LENGTH:     cfg.pattern_length <= len_clamped;
        default: ;
      endcase
    end
  end

endmodule

### design/lae_div.sv
module lae_div
  import lae_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  logic              busy;
  logic [DCNT_W-1:0] count;
  logic [DVS_W-1:0]  divisor;
  logic [DVS_W:0]    trial;
  logic              fits;

  // one restoring step: shift in next dividend bit, compare, subtract
  assign trial = {remainder, quotient[DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DCNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quotient  <= req.dividend;
      remainder <= '0;
      divisor   <= req.divisor;
    end else if (busy) begin
      quotient  <= {quotient[DIV_W-2:0], fits};
      remainder <= fits ? DVS_W'(trial - {1'b0, divisor}) : trial[DVS_W-1:0];
    end
  end

endmodule

### design/lae_ctrl.sv
module lae_ctrl
  import lae_pkg::*;
#(
  parameter int MAX_STEPS = MaxStepsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             mode_wr,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] command,
  input  logic [IDX_W-1:0] step_index,
  input  logic [MS_W-1:0]  step_ms,
  output div_req_t         div_req,
  input  logic             div_done,
  input  logic [DIV_W-1:0] div_quo,
  input  logic [DVS_W-1:0] div_rem,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  localparam int ADDR_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int XW     = ((ADDR_W > LEN_W) ? ADDR_W : LEN_W) + 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_EMOD   = 4'd2;
  localparam logic [3:0] S_PMOD   = 4'd3;
  localparam logic [3:0] S_EVAL   = 4'd4;
  localparam logic [3:0] S_TMOD   = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_DSTART = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0]        state, state_next;
  logic [CMD_W-1:0]  cmd;
  logic [IDX_W-1:0]  idx;
  logic [MS_W-1:0]   ms;
  logic              lit_flag, lit_flag_next;
  logic              running, running_next;
  logic [MS_W-1:0]   elapsed, elapsed_next;
  logic [LEN_W-1:0]  step_pos, step_pos_next;
  logic [MS_W-1:0]   span, span_next;
  logic [23:0]       prod;
  logic [DUTY_W-1:0] duty_raw, duty_raw_next;

  logic [MS_W-1:0]   table_mem [MAX_STEPS];
  logic [MS_W-1:0]   rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_in_range;
  logic              tbl_we;
  logic [MS_W-1:0]   ms_clamped;

  logic [MS_W-1:0]   dur;
  logic [MS_W-1:0]   elapsed_sat;
  logic [MS_W:0]     two_t;
  logic [MS_W:0]     two_rest;
  logic              anim;

  // step table, read at the current step, written by load commands
  assign rd_addr     = ADDR_W'(XW'(step_pos));
  assign rd_in_range = XW'(step_pos) < XW'(MAX_STEPS);
  assign ms_clamped  = (ms == '0) ? MS_MIN : ((ms > MS_MAX) ? MS_MAX : ms);
  assign tbl_we      = (state == S_EXEC) && (cmd == CMD_LOAD)
                       && (XW'(idx) < XW'(MAX_STEPS));

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      table_mem[ADDR_W'(XW'(idx))] <= ms_clamped;
    end
    rd_data <= table_mem[rd_addr];
  end

  // tick helpers
  assign dur         = rd_in_range ? rd_data : '0;
  assign elapsed_sat = (elapsed != ELAPSED_MAX) ? elapsed + 1'b1 : elapsed;
  assign anim        = running && (cfg.mode != MODE_STATIC);
  assign two_t       = {div_rem, 1'b0};
  assign two_rest    = {cfg.pulse_period - div_rem, 1'b0};

  // sequencer
  always_comb begin
    state_next    = state;
    lit_flag_next = lit_flag;
    running_next  = running;
    elapsed_next  = elapsed;
    step_pos_next = step_pos;
    span_next     = span;
    duty_raw_next = duty_raw;
    div_req       = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_EVAL;
        priority case (cmd)
          CMD_TICK: begin
            if (running) begin
              unique case (cfg.mode)
                MODE_BLINK: begin
                  if (cfg.blink_interval != '0 && elapsed_sat >= cfg.blink_interval) begin
                    elapsed_next  = '0;
                    lit_flag_next = !lit_flag;
                  end else begin
                    elapsed_next = elapsed_sat;
                  end
                end
                MODE_PATTERN: begin
                  if (elapsed_sat >= dur) begin
                    elapsed_next     = '0;
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'({1'b0, step_pos} + 1'b1);
                    div_req.divisor  = DVS_W'(cfg.pattern_length);
                    state_next       = S_PMOD;
                  end else begin
                    elapsed_next = elapsed_sat;
                  end
                end
                MODE_PULSE: begin
                  div_req.start    = 1'b1;
                  div_req.dividend = DIV_W'({1'b0, elapsed} + 1'b1);
                  div_req.divisor  = cfg.pulse_period;
                  state_next       = S_EMOD;
                end
                default: ;
              endcase
            end
          end
          CMD_RESTART: begin
            elapsed_next  = '0;
            step_pos_next = '0;
            running_next  = cfg.mode != MODE_STATIC;
            if (cfg.mode == MODE_PATTERN) begin
              lit_flag_next = 1'b1;
            end
          end
          CMD_ON: begin
            running_next  = 1'b0;
            lit_flag_next = 1'b1;
          end
          CMD_OFF: begin
            running_next  = 1'b0;
            lit_flag_next = 1'b0;
          end
          CMD_TOGGLE: begin
            running_next  = 1'b0;
            lit_flag_next = !lit_flag;
          end
          default: ;
        endcase
      end
      S_EMOD: begin
        if (div_done) begin
          elapsed_next = div_rem;
          state_next   = S_EVAL;
        end
      end
      S_PMOD: begin
        if (div_done) begin
          step_pos_next = div_rem[LEN_W-1:0];
          lit_flag_next = !div_rem[0];
          state_next    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (anim && cfg.mode == MODE_PULSE) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(elapsed);
          div_req.divisor  = cfg.pulse_period;
          state_next       = S_TMOD;
        end else begin
          duty_raw_next = lit_flag ? cfg.brightness : '0;
          state_next    = S_OUT;
        end
      end
      S_TMOD: begin
        // triangle: rising half 2t, falling half 2(P-t)
        if (div_done) begin
          span_next  = (two_t < {1'b0, cfg.pulse_period}) ? two_t[MS_W-1:0]
                                                          : two_rest[MS_W-1:0];
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_DSTART;
      end
      S_DSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(prod);
        div_req.divisor  = cfg.pulse_period;
        state_next       = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          duty_raw_next = div_quo[DUTY_W-1:0];
          lit_flag_next = div_quo[DUTY_W-1:0] != '0;
          state_next    = S_OUT;
        end
      end
      S_OUT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      lit_flag <= 1'b0;
      running  <= 1'b0;
      elapsed  <= '0;
      step_pos <= '0;
    end else begin
      state    <= state_next;
      lit_flag <= lit_flag_next;
      running  <= mode_wr ? 1'b0 : running_next;
      elapsed  <= elapsed_next;
      step_pos <= step_pos_next;
    end
  end

  // latched word and datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd <= command;
      idx <= step_index;
      ms  <= step_ms;
    end
    span     <= span_next;
    prod     <= span * cfg.brightness;
    duty_raw <= duty_raw_next;
  end

  // handshake and result
  assign in_ready      = state == S_IDLE;
  assign res_valid     = state == S_OUT;
  assign res.duty      = cfg.active_high ? duty_raw : ~duty_raw;
  assign res.lit       = lit_flag;
  assign res.step_now  = step_pos[IDX_W-1:0];
  assign res.animating = anim;

endmodule

### design/led_animation_engine_top.sv
// a pattern step change takes one pass of the shared divider, and a word in a running
// pulse animation up to three passes; other commands do not use the divider
// handshake: one word at a time; a new word is taken only after the result of the
// last one has moved into the output register, so output stalls also hold the input
// reset: control state and config registers return to defaults; the step table and datapath registers are not cleared
module led_animation_engine_top
  import lae_pkg::*;
#(
  parameter int MAX_STEPS = MaxStepsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  command,
  input  logic [IDX_W-1:0]  step_index,
  input  logic [MS_W-1:0]   step_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DUTY_W-1:0] duty,
  output logic              lit,
  output logic [IDX_W-1:0]  step_now,
  output logic              animating
);

  cfg_t             cfg;
  logic             mode_wr;
  div_req_t         div_req;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic [DVS_W-1:0] div_rem;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  lae_regs #(.MAX_STEPS(MAX_STEPS)) u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .mode_wr   (mode_wr)
  );

  lae_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  lae_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .mode_wr    (mode_wr),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .step_index (step_index),
    .step_ms    (step_ms),
    .div_req    (div_req),
    .div_done   (div_done),
    .div_quo    (div_quo),
    .div_rem    (div_rem),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      duty      <= res.duty;
      lit       <= res.lit;
      step_now  <= res.step_now;
      animating <= res.animating;
    end
  end

endmodule

### verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lae_pkg::*;

  // spare command codes the block must answer without acting on them
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  localparam int unsigned STALL_LIMIT    = 5000;
  localparam int unsigned ZERO_IVL_TICKS = 60;
  localparam int unsigned RAND_PHASES    = 24;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic [IDX_W-1:0] slot;
    logic [MS_W-1:0]  ms;
  } cmd_word_t;

  // clock, reset and block ports
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CFGI_W-1:0] cfg_index = REG_MODE;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  command = CMD_TICK;
  logic [IDX_W-1:0]  step_index = '0;
  logic [MS_W-1:0]   step_ms = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DUTY_W-1:0] duty;
  logic              lit;
  logic [IDX_W-1:0]  step_now;
  logic              animating;

  // words waiting to be sent and predicted led outputs waiting to arrive
  cmd_word_t cmd_q[$];
  res_t      led_out_q[$];

  bit          idle_on = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned stall_cycles = 0;
  int unsigned err_count = 0;

  // registers touched in random phases besides the mode
  logic [CFGI_W-1:0] side_regs[5] = '{REG_BRIGHTNESS, REG_ACTIVE_HI, REG_BLINK,
                                      REG_PERIOD, REG_LENGTH};

  // predicted register file
  logic [MODE_W-1:0] cur_mode = MODE_STATIC;
  logic [DUTY_W-1:0] cur_bright = BRIGHT_RESET;
  logic              cur_act_hi = 1'b1;
  logic [MS_W-1:0]   cur_blink = BLINK_RESET;
  logic [MS_W-1:0]   cur_period = PERIOD_RESET;
  logic [LEN_W-1:0]  cur_len = LEN_MIN;

  // predicted animation state
  logic        lamp_on = 1'b0;
  logic        anim_run = 1'b0;
  int unsigned elapsed = 0;
  int unsigned step_at = 0;
  logic [MS_W-1:0] step_len_tbl[MaxStepsDefault];

  led_animation_engine_top u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .step_index (step_index),
    .step_ms    (step_ms),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .duty       (duty),
    .lit        (lit),
    .step_now   (step_now),
    .animating  (animating)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag_err(input string msg);
    // log capped so a broken build stays readable
    if (err_count < 200) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // register write as the block applies it
  function automatic void set_reg(input logic [CFGI_W-1:0] idx, input logic [CFG_W-1:0] val);
    logic [LEN_W-1:0] len_v;
    case (idx)
      REG_MODE: begin
        cur_mode = val[MODE_W-1:0];
        anim_run = 1'b0;
      end
      REG_BRIGHTNESS: cur_bright = val[DUTY_W-1:0];
      REG_ACTIVE_HI:  cur_act_hi = val[0];
      REG_BLINK:      cur_blink = val;
      REG_PERIOD:     cur_period = (val < PERIOD_MIN) ? PERIOD_MIN : val;
      REG_LENGTH: begin
        len_v = val[LEN_W-1:0];
        if (len_v < LEN_MIN) len_v = LEN_MIN;
        if (len_v > MaxStepsDefault) len_v = LEN_W'(MaxStepsDefault);
        cur_len = len_v;
      end
      default: ;
    endcase
  endfunction

  // one command applied to the led state, returning the outputs it leaves
  function automatic res_t run_led_cmd(input cmd_word_t w);
    res_t            r;
    int unsigned     dur;
    int unsigned     t;
    int unsigned     span;
    int unsigned     lvl;
    logic [MS_W-1:0] clamped;
    logic            anim;
    case (w.op)
      CMD_TICK: begin
        if (anim_run && cur_mode == MODE_BLINK) begin
          if (elapsed < ELAPSED_MAX) elapsed++;
          if (cur_blink != 0 && elapsed >= cur_blink) begin
            elapsed = 0;
            lamp_on = ~lamp_on;
          end
        end else if (anim_run && cur_mode == MODE_PATTERN) begin
          // duration read before the count moves, even for a stale step
          dur = step_len_tbl[step_at];
          if (elapsed < ELAPSED_MAX) elapsed++;
          if (elapsed >= dur) begin
            elapsed = 0;
            step_at = (step_at + 1) % cur_len;
            lamp_on = (step_at % 2) == 0;
          end
        end else if (anim_run && cur_mode == MODE_PULSE) begin
          elapsed = (elapsed + 1) % cur_period;
        end
      end
      CMD_LOAD: begin
        clamped = w.ms;
        if (clamped < MS_MIN) clamped = MS_MIN;
        if (clamped > MS_MAX) clamped = MS_MAX;
        step_len_tbl[w.slot] = clamped;
      end
      CMD_RESTART: begin
        elapsed = 0;
        step_at = 0;
        anim_run = (cur_mode != MODE_STATIC);
        if (cur_mode == MODE_PATTERN) lamp_on = 1'b1;
      end
      CMD_ON: begin
        anim_run = 1'b0;
        lamp_on = 1'b1;
      end
      CMD_OFF: begin
        anim_run = 1'b0;
        lamp_on = 1'b0;
      end
      CMD_TOGGLE: begin
        anim_run = 1'b0;
        lamp_on = ~lamp_on;
      end
      default: ;
    endcase
    anim = anim_run && cur_mode != MODE_STATIC;
    // triangle wave: rising half 2t*b/P, falling half 2(P-t)*b/P
    if (anim && cur_mode == MODE_PULSE) begin
      t = elapsed % cur_period;
      span = (2 * t < cur_period) ? 2 * t : 2 * (cur_period - t);
      lvl = span * cur_bright / cur_period;
      lamp_on = (lvl != 0);
    end else begin
      lvl = lamp_on ? cur_bright : 0;
    end
    if (!cur_act_hi) lvl = 255 - lvl;
    r.duty = lvl[DUTY_W-1:0];
    r.lit = lamp_on;
    r.step_now = step_at[IDX_W-1:0];
    r.animating = anim;
    return r;
  endfunction

  // input side: present queued words, with random gaps
  always @(posedge clk) begin : feed_words
    cmd_word_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready)
        led_out_q.push_back(run_led_cmd(cmd_word_t'{command, step_index, step_ms}));
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (idle_on && cmd_q.size() != 0 && $urandom_range(0, 11) == 0) begin
          send_gap <= $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          nxt = cmd_q.pop_front();
          in_valid <= 1'b1;
          command <= nxt.op;
          step_index <= nxt.slot;
          step_ms <= nxt.ms;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: compare each result word, stall at random
  always @(posedge clk) begin : take_results
    res_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (led_out_q.size() == 0) begin
          flag_err("result word with nothing expected");
        end else begin
          want = led_out_q.pop_front();
          if (duty !== want.duty)
            flag_err($sformatf("duty %0d, expected %0d", duty, want.duty));
          if (lit !== want.lit)
            flag_err($sformatf("lit %0b, expected %0b", lit, want.lit));
          if (step_now !== want.step_now)
            flag_err($sformatf("step_now %0d, expected %0d", step_now, want.step_now));
          if (animating !== want.animating)
            flag_err($sformatf("animating %0b, expected %0b", animating, want.animating));
        end
      end
      if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic void push_word(input logic [CMD_W-1:0] op, input int unsigned slot,
                                    input int unsigned ms);
    cmd_word_t w;
    w.op = op;
    w.slot = slot[IDX_W-1:0];
    w.ms = ms[MS_W-1:0];
    cmd_q.push_back(w);
  endfunction

  // mostly ticks, so animations get deep; the rest interrupts them
  function automatic cmd_word_t pick_word();
    cmd_word_t   w;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    w.slot = IDX_W'($urandom_range(0, 31));
    w.ms = MS_W'($urandom_range(0, 65535));
    if (roll < 80) begin
      w.op = CMD_TICK;
    end else if (roll < 88) begin
      w.op = CMD_LOAD;
      roll = $urandom_range(0, 31);
      if (roll == 1) w.ms = '0;
      else if (roll != 0) w.ms = MS_W'($urandom_range(1, 8));
    end else if (roll < 92) begin
      w.op = CMD_RESTART;
    end else if (roll < 94) begin
      w.op = CMD_ON;
    end else if (roll < 96) begin
      w.op = CMD_OFF;
    end else if (roll < 98) begin
      w.op = CMD_TOGGLE;
    end else if (roll < 99) begin
      w.op = CMD_SPARE6;
    end else begin
      w.op = CMD_SPARE7;
    end
    return w;
  endfunction

  // register values: mostly short timing, sometimes clamp cases and full range
  function automatic logic [CFG_W-1:0] pick_reg_val(input logic [CFGI_W-1:0] idx);
    int unsigned     roll;
    logic [CFG_W-1:0] v;
    roll = $urandom_range(0, 7);
    v = '0;
    case (idx)
      REG_MODE: begin
        if (roll == 0) v = CFG_W'(MODE_STATIC);
        else if (roll < 3) v = CFG_W'(MODE_BLINK);
        else if (roll < 6) v = CFG_W'(MODE_PATTERN);
        else v = CFG_W'(MODE_PULSE);
      end
      REG_BRIGHTNESS:
        v = CFG_W'((roll == 0) ? 0 : (roll == 1) ? 255 : $urandom_range(0, 255));
      REG_ACTIVE_HI:  v = CFG_W'($urandom_range(0, 1));
      REG_BLINK:
        v = CFG_W'((roll == 0) ? 0 :
                   (roll == 1) ? $urandom_range(0, 65535) : $urandom_range(1, 10));
      REG_PERIOD:
        v = CFG_W'((roll == 0) ? $urandom_range(0, 199) :
                   (roll == 1) ? $urandom_range(0, 65535) : $urandom_range(200, 230));
      REG_LENGTH:
        v = CFG_W'((roll < 2) ? $urandom_range(0, 63) : $urandom_range(2, 6));
      default: ;
    endcase
    return v;
  endfunction

  // write one register while the block is idle
  task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_reg(idx, val);
    @(negedge clk);
  endtask

  // hold off until every queued word has been sent and answered
  task automatic drain_words();
    do @(negedge clk);
    while (cmd_q.size() != 0 || in_valid || led_out_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned i;
    int unsigned ph;
    int unsigned nitems;
    int          ri;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    idle_on = 1'b1;

    // every command but load in static mode, spare codes, restart with no animation
    push_word(CMD_TICK, 0, 0);
    push_word(CMD_ON, 31, 65535);
    push_word(CMD_OFF, 0, 0);
    push_word(CMD_TOGGLE, 21, 43690);
    push_word(CMD_TOGGLE, 10, 21845);
    push_word(CMD_SPARE6, 0, 0);
    push_word(CMD_SPARE7, 31, 65535);
    push_word(CMD_RESTART, 0, 0);
    // loads at the clamp edges
    push_word(CMD_LOAD, 0, 0);
    push_word(CMD_LOAD, 1, 65535);
    push_word(CMD_LOAD, 2, MS_MAX);
    push_word(CMD_LOAD, 3, MS_MAX + 16'd1);
    push_word(CMD_LOAD, 31, MS_MIN);
    // whole step table gets short durations before any pattern runs
    for (i = 0; i < MaxStepsDefault; i++) push_word(CMD_LOAD, i, $urandom_range(1, 6));
    drain_words();

    // polarity and brightness extremes
    write_reg(REG_BRIGHTNESS, 0);
    write_reg(REG_ACTIVE_HI, 0);
    push_word(CMD_ON, 0, 0);
    push_word(CMD_OFF, 0, 0);
    drain_words();
    write_reg(REG_BRIGHTNESS, 255);
    push_word(CMD_ON, 0, 0);
    push_word(CMD_TOGGLE, 0, 0);
    drain_words();
    write_reg(REG_ACTIVE_HI, 1);

    // short blink, stopped by a toggle
    write_reg(REG_MODE, CFG_W'(MODE_BLINK));
    write_reg(REG_BLINK, 2);
    push_word(CMD_RESTART, 0, 0);
    repeat (5) push_word(CMD_TICK, 0, 0);
    push_word(CMD_TOGGLE, 0, 0);
    push_word(CMD_TICK, 0, 0);
    drain_words();

    // pattern with length clamped high, a load mid-run, then a stale step
    write_reg(REG_MODE, CFG_W'(MODE_PATTERN));
    write_reg(REG_LENGTH, 63);
    push_word(CMD_RESTART, 0, 0);
    push_word(CMD_LOAD, 5, 3);
    drain_words();
    for (i = 0; i < 64 && step_at < 2; i++) begin
      push_word(CMD_TICK, 0, 0);
      drain_words();
    end
    write_reg(REG_LENGTH, 0);
    repeat (4) push_word(CMD_TICK, 0, 0);
    drain_words();

    // pulse with period clamped low, then stretched while running
    write_reg(REG_MODE, CFG_W'(MODE_PULSE));
    write_reg(REG_PERIOD, 0);
    push_word(CMD_RESTART, 0, 0);
    repeat (6) push_word(CMD_TICK, 0, 0);
    drain_words();
    write_reg(REG_PERIOD, 65535);
    repeat (3) push_word(CMD_TICK, 0, 0);
    drain_words();

    // blink with interval zero never toggles, then a long interval keeps counting
    idle_on = 1'b0;
    write_reg(REG_MODE, CFG_W'(MODE_BLINK));
    write_reg(REG_BLINK, 0);
    push_word(CMD_RESTART, 0, 0);
    for (i = 0; i < ZERO_IVL_TICKS; i++) push_word(CMD_TICK, 0, 0);
    drain_words();
    write_reg(REG_BLINK, 65535);
    push_word(CMD_TICK, 0, 0);
    push_word(CMD_TICK, 0, 0);
    drain_words();

    // random phases, registers changed between them
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      idle_on = (ph + 3 < RAND_PHASES) && (ph % 6 != 5);
      if ($urandom_range(0, 2) != 0) begin
        write_reg(REG_MODE, pick_reg_val(REG_MODE));
        for (ri = 0; ri < 5; ri++)
          if ($urandom_range(0, 1) != 0) write_reg(side_regs[ri], pick_reg_val(side_regs[ri]));
        push_word(CMD_RESTART, $urandom_range(0, 31), $urandom_range(0, 65535));
      end else begin
        // animation keeps running across these writes
        for (ri = 0; ri < 5; ri++)
          if ($urandom_range(0, 2) == 0) write_reg(side_regs[ri], pick_reg_val(side_regs[ri]));
      end
      nitems = $urandom_range(35, 65);
      for (i = 0; i < nitems; i++) cmd_q.push_back(pick_word());
      drain_words();
    end

    repeat (100) @(negedge clk);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
design/lae_pkg.sv
design/lae_regs.sv
design/lae_div.sv
design/lae_ctrl.sv
design/led_animation_engine_top.sv
verif/tb_top.sv
